// ===== rtl/front_middle_back_queue_core_macros.svh =====
// Assertion macros shared by the queue core modules.
// No dependencies; included by the files that carry assertions.
`ifndef FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FMBQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmbq assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FMBQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmbq assertion failed");

`endif

// ===== rtl/fmbq_pkg.sv =====
// Shared types and constants for the front/middle/back queue core.
// No dependencies; imported by the controller, datapath and top level.
package fmbq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              accept;      // latch push value
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_from_rd;  // 1: write read data, 0: write push value
        logic              capture;     // hold read data as popped value
        logic              finish;      // load the result registers and raise done
        status_t           fin_status;
        logic              fin_pop;     // result carries popped value
        logic              count_inc;
        logic              count_dec;
    } cmd_t;

endpackage

// ===== rtl/front_middle_back_queue_core.sv =====
// Top level of the front/middle/back queue core.
// Depends on fmbq_pkg, fmbq_ctrl and fmbq_dp.
//
// Usage: drive opcode and push_value with start high; the transaction is taken
// at a rising edge where start is high and busy is low. Each transaction gives
// exactly one result, shown on pop_value, status and occupancy for one cycle
// while done is high. The receiver cannot stall; results never wait.
// Ops: push front, push middle (index n/2), push back, pop front, pop middle
// (index (n-1)/2), pop back. Pops on an empty queue report empty status; pushes
// on a full queue are dropped and report full status.
// Rejected or unused opcode: result the cycle after accept, busy stays low.
// A push moves the entries from index p to n-1 (n the count before the op)
// one cell up, back to front, then writes the new value at p; a pop reads
// index p, then moves the entries above it one cell down. Each cell move is
// a read of the cell memory followed by a write. A new transaction is taken
// the cycle busy drops, which is the cycle its predecessor's result is shown.
// Reset clears the entry count and the controller; cell contents are undefined
// but never read before written. No clearing pass is needed.
module front_middle_back_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] push_value,
    output logic        done,
    output logic [31:0] pop_value,
    output logic [1:0]  status,
    output logic [6:0]  occupancy
);
    import fmbq_pkg::*;

    cmd_t             cmd;
    logic [CNT_W-1:0] count;

    // Sequencer
    fmbq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .count  (count),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Storage and results
    fmbq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (push_value),
        .count      (count),
        .done       (done),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule

// ===== rtl/fmbq_dp.sv =====
// Datapath of the queue core: cell memory, entry count and result registers.
// Depends on fmbq_pkg and the assertion macro header.
`include "front_middle_back_queue_core_macros.svh"

module fmbq_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fmbq_pkg::cmd_t              cmd,
    input  logic [31:0]                 push_value,
    output logic [fmbq_pkg::CNT_W-1:0]  count,
    output logic                        done,
    output logic [31:0]                 pop_value,
    output logic [1:0]                  status,
    output logic [6:0]                  occupancy
);
    import fmbq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] push_hold_reg;
    logic [DATA_WIDTH-1:0] pop_hold_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg;
    logic [31:0]           pop_value_reg;
    logic [1:0]            status_reg;
    logic [6:0]            occupancy_reg;

    // Cell memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_from_rd ? rd_data_reg : push_hold_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            push_hold_reg <= DATA_WIDTH'(push_value);
        end
        if (cmd.capture)
        begin
            pop_hold_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            pop_value_reg <= cmd.fin_pop ? 32'($signed(pop_hold_reg)) : 32'd0;
            status_reg    <= cmd.fin_status;
            occupancy_reg <= 7'(count_next);
        end
    end

    // Entry count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.finish && cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    assign count     = count_reg;
    assign done      = done_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // Checks
    `FMBQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `FMBQ_ASSERT_NEXT(a_count_only_on_finish, !cmd.finish, $stable(count_reg))
    `FMBQ_ASSERT_SAME(a_occ_tracks_count, done_reg, occupancy_reg == 7'(count_reg))

endmodule

// ===== rtl/fmbq_ctrl.sv =====
// Controller of the queue core: decodes a transaction and sequences the cell moves.
// Depends on fmbq_pkg and the assertion macro header.
`include "front_middle_back_queue_core_macros.svh"

module fmbq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2:0]                  opcode,
    input  logic [fmbq_pkg::CNT_W-1:0]  count,
    output logic                        busy,
    output fmbq_pkg::cmd_t              cmd
);
    import fmbq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_WR  = 8'b0000_0100,
        S_INS_PUT = 8'b0000_1000,
        S_REM_RD  = 8'b0001_0000,
        S_REM_CAP = 8'b0010_0000,
        S_MV_RD   = 8'b0100_0000,
        S_MV_WR   = 8'b1000_0000
    } state_t;

    // Note: removal finishes from S_MV_WR or S_REM_CAP via the rem_end_reg wrap-up step
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             rem_end_reg, rem_end_next;
    logic [CNT_W-1:0] ptr_m1, ptr_p1, ptr_p2;
    logic [CNT_W-1:0] push_pos, pop_pos, count_m1;
    logic             is_push, is_pop;

    assign ptr_m1   = ptr_reg - 1'b1;
    assign ptr_p1   = ptr_reg + 1'b1;
    assign ptr_p2   = ptr_reg + CNT_W'(2);
    assign count_m1 = count - 1'b1;

    // Opcode decode and target index
    always_comb
    begin
        is_push  = 1'b0;
        is_pop   = 1'b0;
        push_pos = '0;
        pop_pos  = '0;
        case (opcode)
            OP_PUSH_FRONT:  begin is_push = 1'b1; push_pos = '0; end
            OP_PUSH_MIDDLE: begin is_push = 1'b1; push_pos = count >> 1; end
            OP_PUSH_BACK:   begin is_push = 1'b1; push_pos = count; end
            OP_POP_FRONT:   begin is_pop = 1'b1; pop_pos = '0; end
            OP_POP_MIDDLE:  begin is_pop = 1'b1; pop_pos = count_m1 >> 1; end
            OP_POP_BACK:    begin is_pop = 1'b1; pop_pos = count_m1; end
            default:        begin is_push = 1'b0; is_pop = 1'b0; end
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        rem_end_next = 1'b0;
        cmd          = '0;
        cmd.fin_status = ST_OK;
        if (rem_end_reg)
        begin
            // Removal wrap-up: drop the count and publish the popped value
            cmd.finish    = 1'b1;
            cmd.fin_pop   = 1'b1;
            cmd.count_dec = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start && !rem_end_reg)
                begin
                    cmd.accept = 1'b1;
                    if (is_push)
                    begin
                        if (count == CNT_W'(CAPACITY))
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_FULL;
                        end
                        else
                        begin
                            pos_next   = push_pos;
                            ptr_next   = count;
                            state_next = (count == push_pos) ? S_INS_PUT : S_INS_RD;
                        end
                    end
                    else if (is_pop)
                    begin
                        if (count == '0)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_EMPTY;
                        end
                        else
                        begin
                            pos_next   = pop_pos;
                            ptr_next   = pop_pos;
                            state_next = S_REM_RD;
                        end
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                    end
                end
            end
            S_INS_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = ptr_m1[ADDR_W-1:0];
                state_next  = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_addr    = ptr_reg[ADDR_W-1:0];
                cmd.wr_from_rd = 1'b1;
                ptr_next       = ptr_m1;
                state_next     = (ptr_m1 == pos_reg) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_addr   = pos_reg[ADDR_W-1:0];
                cmd.finish    = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_IDLE;
            end
            S_REM_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = ptr_reg[ADDR_W-1:0];
                state_next  = S_REM_CAP;
            end
            S_REM_CAP:
            begin
                cmd.capture = 1'b1;
                if (ptr_p1 < count)
                begin
                    state_next = S_MV_RD;
                end
                else
                begin
                    rem_end_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MV_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = ptr_p1[ADDR_W-1:0];
                state_next  = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_addr    = ptr_reg[ADDR_W-1:0];
                cmd.wr_from_rd = 1'b1;
                ptr_next       = ptr_p1;
                if (ptr_p2 < count)
                begin
                    state_next = S_MV_RD;
                end
                else
                begin
                    rem_end_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rem_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rem_end_reg <= rem_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
    end

    assign busy = (state_reg != S_IDLE) || rem_end_reg;

    // Checks
    `FMBQ_ASSERT_SAME(a_pop_empty_flags,
        start && !busy && is_pop && (count == '0),
        cmd.finish && (cmd.fin_status == ST_EMPTY) && !cmd.count_dec)
    `FMBQ_ASSERT_NEXT(a_ins_ptr_steps_down, state_reg == S_INS_WR,
        ptr_reg == $past(ptr_reg) - 1'b1)
    `FMBQ_ASSERT_SAME(a_ptr_in_range, state_reg != S_IDLE, ptr_reg <= count)

endmodule

// ===== tb/sv/front_middle_back_queue_checker.sv =====
// Result checker for the front/middle/back queue core: predicts each result
// from the accepted transactions and compares it with the block's output.
// Depends on fmbq_pkg for the opcode and status codes and the queue sizes.
module front_middle_back_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] push_value,
    input  logic        done,
    input  logic [31:0] pop_value,
    input  logic [1:0]  status,
    input  logic [6:0]  occupancy,
    output int          mismatch_count,
    output int          pending,
    output int          checked,
    output int          empty_pops,
    output int          full_pushes,
    output int          peak_count
);
    import fmbq_pkg::*;

    typedef struct packed {
        logic [31:0] pop_value;
        status_t     status;
        logic [6:0]  occupancy;
    } queue_result_t;

    // Shadow copy of the stored entries, index 0 is the front
    logic [DATA_WIDTH-1:0] shadow_cells[$];
    // Results owed by the block, oldest first
    queue_result_t         results_due[$];

    int n_mismatch = 0;
    int n_checked  = 0;
    int n_empty    = 0;
    int n_full     = 0;
    int n_peak     = 0;

    // Apply one operation to the shadow queue and return the result it gives
    function automatic queue_result_t apply_queue_op(logic [2:0] op,
                                                     logic [31:0] val);
        queue_result_t         res;
        logic [DATA_WIDTH-1:0] taken;
        int                    n;
        int                    idx;
        n             = shadow_cells.size();
        res.pop_value = '0;
        res.status    = ST_OK;
        taken         = '0;
        idx           = 0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK:
            begin
                if (n >= CAPACITY)
                begin
                    res.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                        idx = 0;
                    else if (op == OP_PUSH_MIDDLE)
                        idx = n / 2;
                    else
                        idx = n;
                    shadow_cells.insert(idx, val[DATA_WIDTH-1:0]);
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:
            begin
                if (n == 0)
                begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                        idx = 0;
                    else if (op == OP_POP_MIDDLE)
                        idx = (n - 1) / 2;
                    else
                        idx = n - 1;
                    taken = shadow_cells[idx];
                    shadow_cells.delete(idx);
                    // sign-extend the stored width out to the port
                    res.pop_value = 32'($signed(taken));
                end
            end
            default:
            begin
                // spare opcodes leave the queue alone
            end
        endcase
        res.occupancy = 7'(shadow_cells.size());
        if (shadow_cells.size() > n_peak)
            n_peak = shadow_cells.size();
        return res;
    endfunction

    // Compare finished results first, then record the transaction taken here
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n)
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"%0t: result with none outstanding: ",
                                  "pop_value=%h status=%0d occ=%0d"},
                                 $realtime, pop_value, status, occupancy);
                end
                else
                begin
                    exp_res = results_due[0];
                    results_due.delete(0);
                    n_checked++;
                    if (pop_value !== exp_res.pop_value || status !== exp_res.status ||
                        occupancy !== exp_res.occupancy)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"%0t: mismatch: pop_value exp %h got %h, ",
                                      "status exp %0d got %0d, occ exp %0d got %0d"},
                                     $realtime, exp_res.pop_value, pop_value,
                                     exp_res.status, status, exp_res.occupancy,
                                     occupancy);
                    end
                end
            end
            if (start && !busy)
                results_due.insert(results_due.size(),
                                   apply_queue_op(opcode, push_value));
        end
        mismatch_count <= n_mismatch;
        pending        <= results_due.size();
        checked        <= n_checked;
        empty_pops     <= n_empty;
        full_pushes    <= n_full;
        peak_count     <= n_peak;
    end

endmodule

// ===== tb/sv/tb_front_middle_back_queue_core.sv =====
// Top of the front/middle/back queue core testbench: clock, reset, stimulus
// and verdict. Depends on fmbq_pkg, the core and front_middle_back_queue_checker.
module tb_front_middle_back_queue_core;
    import fmbq_pkg::*;

    // Opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 140;       // longer than the slowest op
    localparam int DRAIN_LIMIT   = 2000;
    localparam int RUN_LIMIT     = 5_000_000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [2:0]  opcode     = '0;
    logic [31:0] push_value = '0;
    logic        busy;
    logic        done;
    logic [31:0] pop_value;
    logic [1:0]  status;
    logic [6:0]  occupancy;

    int mismatch_count;
    int pending;
    int checked;
    int empty_pops;
    int full_pushes;
    int peak_count;
    int items_sent = 0;

    always #5 clk = ~clk;

    front_middle_back_queue_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .push_value (push_value),
        .done       (done),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    front_middle_back_queue_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .push_value     (push_value),
        .done           (done),
        .pop_value      (pop_value),
        .status         (status),
        .occupancy      (occupancy),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .checked        (checked),
        .empty_pops     (empty_pops),
        .full_pushes    (full_pushes),
        .peak_count     (peak_count)
    );

    // Mostly random data, with the extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Opcode mix: push_pct of the real ops are pushes, a few spare codes
    function automatic logic [2:0] pick_op(int push_pct);
        if ($urandom_range(0, 99) < 3)
            return ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        if ($urandom_range(0, 99) < push_pct) begin
            case ($urandom_range(0, 2))
                0: return OP_PUSH_FRONT;
                1: return OP_PUSH_MIDDLE;
                default: return OP_PUSH_BACK;
            endcase
        end
        case ($urandom_range(0, 2))
            0: return OP_POP_FRONT;
            1: return OP_POP_MIDDLE;
            default: return OP_POP_BACK;
        endcase
    endfunction

    // Drive one transaction at the falling edge, hold it until it is taken
    task automatic issue_op(input logic [2:0] op, input logic [31:0] val, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start      <= 1'b0;
            opcode     <= 3'($urandom);
            push_value <= $urandom;
            repeat (gap) @(negedge clk);
        end
        opcode     <= op;
        push_value <= val;
        start      <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic run_phase(input int count, input int push_pct, input bit may_idle);
        repeat (count) issue_op(pick_op(push_pct), pick_value(), may_idle);
    endtask

    // Stimulus and verdict
    initial
    begin
        int waited;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pops and spare codes on the empty queue
        issue_op(OP_POP_FRONT, 32'h1234_5678, 1'b0);
        issue_op(OP_POP_MIDDLE, 32'hFFFF_FFFF, 1'b0);
        issue_op(OP_POP_BACK, 32'h8000_0000, 1'b0);
        issue_op(OP_SPARE_LO, 32'h7FFF_FFFF, 1'b0);
        issue_op(OP_SPARE_HI, 32'h0000_0001, 1'b0);
        // every push kind, extreme values, middle inserts at odd and even counts
        issue_op(OP_PUSH_MIDDLE, 32'h8000_0000, 1'b0);
        issue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1);
        issue_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
        issue_op(OP_PUSH_MIDDLE, 32'h0000_0000, 1'b1);
        issue_op(OP_PUSH_MIDDLE, 32'h5555_5555, 1'b0);
        issue_op(OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0);
        issue_op(OP_PUSH_BACK, 32'h0000_0001, 1'b1);
        // every pop kind, middle removals down to empty
        issue_op(OP_POP_MIDDLE, 32'h0, 1'b0);
        issue_op(OP_POP_MIDDLE, 32'h0, 1'b1);
        issue_op(OP_POP_FRONT, 32'h0, 1'b0);
        issue_op(OP_SPARE_LO, 32'hDEAD_BEEF, 1'b0);
        issue_op(OP_POP_BACK, 32'h0, 1'b0);
        issue_op(OP_POP_MIDDLE, 32'h0, 1'b1);
        issue_op(OP_POP_MIDDLE, 32'h0, 1'b0);
        issue_op(OP_POP_BACK, 32'h0, 1'b0);
        issue_op(OP_POP_FRONT, 32'h0, 1'b0);
        issue_op(OP_POP_MIDDLE, 32'h0, 1'b0);

        // random mixes, then fill past capacity, hover at full, drain past empty
        run_phase(50, 50, 1'b1);
        run_phase(50, 65, 1'b1);
        run_phase(70, 100, 1'b1);
        run_phase(50, 55, 1'b1);
        run_phase(70, 0, 1'b1);
        for (int p = 0; p < 3; p++) begin
            case ($urandom_range(0, 2))
                0: run_phase(50, 30, 1'b1);
                1: run_phase(50, 50, 1'b1);
                default: run_phase(50, 70, 1'b1);
            endcase
        end
        // back to back at full rate
        run_phase(60, 55, 1'b0);
        start <= 1'b0;

        // wait out outstanding results, then watch for strays
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d transactions, checked %0d results; peak count %0d of %0d.",
                 items_sent, checked, peak_count, CAPACITY);
        $display("Pops on empty queue: %0d, pushes dropped when full: %0d.",
                 empty_pops, full_pushes);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (mismatch_count == 0 && pending == 0)
            $display("tb_front_middle_back_queue_core: PASS");
        else
            $display("tb_front_middle_back_queue_core: FAIL");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout after %0d time units", RUN_LIMIT);
        $display("tb_front_middle_back_queue_core: FAIL");
        $finish;
    end

endmodule
